/* hdl/cpa_pkg.sv */
// Shared types, register indexes and helper functions for the cascaded
// proportional acceleration controller. No dependencies.
package cpa_pkg;

  // Request kinds
  localparam logic [1:0] REQ_ODOM  = 2'd0;
  localparam logic [1:0] REQ_GOAL  = 2'd1;
  localparam logic [1:0] REQ_CLOCK = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_VEL_GAIN  = 3'd0;
  localparam logic [2:0] REG_ACC_GAIN  = 3'd1;
  localparam logic [2:0] REG_VEL_LIMIT = 3'd2;
  localparam logic [2:0] REG_ACC_LIMIT = 3'd3;
  localparam logic [2:0] REG_HOLD      = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [31:0]        clock_sec;
    logic [29:0]        clock_nanosec;
  } req_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MULX, S_MULY, S_SQX, S_SQY, S_SQL, S_SQRT,
    S_SCX, S_DIVX, S_SCY, S_DIVY, S_NEXT, S_OUT
  } state_t;

  // Magnitude of a 33 bit signed value
  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  // Magnitude of a 32 bit signed value
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Round a Q.12 product magnitude half away from zero, apply sign, saturate
  function automatic logic [31:0] rnd_sat(input logic [64:0] p, input logic neg);
    logic [52:0] r;
    r = (p[52:0] + 53'd2048) >> 12;
    if (neg) begin
      rnd_sat = (r > 53'h80000000) ? 32'h80000000 : (~r[31:0] + 32'd1);
    end else begin
      rnd_sat = (r > 53'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
    end
  endfunction

endpackage

/* hdl/cpa_mul.sv */
// Bit-serial shift-add multiplier, 33 x 32 bits unsigned, one multiplier
// bit per cycle. Depends on nothing.
module cpa_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [64:0] prod
);

  logic [64:0] mc;
  logic [31:0] mp;
  logic [4:0]  cnt;
  logic        busy;

  // Control: count 32 steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
      mc   <= {32'd0, a};
      mp   <= b;
      cnt  <= 5'd31;
    end else if (busy) begin
      if (mp[0]) begin
        prod <= prod + mc;
      end
      mc  <= mc << 1;
      mp  <= mp >> 1;
      cnt <= cnt - 5'd1;
    end
  end

endmodule

/* hdl/cpa_div.sv */
// Restoring divider, 63 bit dividend by 32 bit divisor, one quotient bit
// per cycle. Depends on nothing.
module cpa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [62:0] dvd;
  logic [31:0] dsr;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] r2;
  logic [32:0] diff;

  assign r2   = {rem, dvd[62]};
  assign diff = r2 - {1'b0, dsr};
  assign quot = dvd[31:0];

  // Control: 63 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: shift in a dividend bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      cnt <= 6'd62;
    end else if (busy) begin
      if (r2 >= {1'b0, dsr}) begin
        rem <= diff[31:0];
        dvd <= {dvd[61:0], 1'b1};
      end else begin
        rem <= r2[31:0];
        dvd <= {dvd[61:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
    end
  end

endmodule

/* hdl/cpa_sqrt.sv */
// Digit-by-digit floor square root of a 64 bit value, one root bit per
// cycle. Depends on nothing.
module cpa_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad_in,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] r2;
  logic [35:0] trial;
  logic [35:0] diff;

  assign r2    = {rem, rad[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign diff  = r2 - trial;

  // Control: 32 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: bring down two radicand bits, try the next root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
      cnt  <= 5'd31;
    end else if (busy) begin
      if (r2 >= trial) begin
        rem  <= diff[33:0];
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= r2[33:0];
        root <= {root[30:0], 1'b0};
      end
      rad <= rad << 2;
      cnt <= cnt - 5'd1;
    end
  end

endmodule

/* hdl/cascaded_p_accel_controller_2d.sv */
// Cascaded proportional controller, top level: sequencer and register file.
// An odometry request runs two passes; a pass that limits runs seven
// multiplies, a root and two divides, and one that does not runs five multiplies.
// Target and clock transactions are stored straight from idle.
// Throughput: one transaction at a time; input reopens once the result is held.
// Synchronous reset restores default registers and zeroes target and time.
module cascaded_p_accel_controller_2d
  import cpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] velocity_gain, accel_gain;
  logic [30:0] velocity_limit, accel_limit;
  logic [31:0] hold_seconds;
  logic [31:0] target_x, target_y, time_sec;
  logic [29:0] time_nanosec;

  state_t state, state_next;
  logic        stage;
  logic [32:0] ex, ey;
  logic [31:0] cx, cy, vx, vy;
  logic [63:0] n2;

  logic        mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [31:0] quot, root;
  logic [15:0] gain;
  logic [30:0] lim;
  logic        past;
  logic [31:0] tgt_x, tgt_y;

  cpa_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                 .done(mul_done), .prod);
  cpa_sqrt u_sqrt (.clk, .rst, .start(sqrt_start), .rad_in(n2),
                   .done(sqrt_done), .root);
  cpa_div u_div (.clk, .rst, .start(div_start), .dividend(prod[62:0]),
                 .divisor(root), .done(div_done), .quot);

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign gain     = stage ? accel_gain : velocity_gain;
  assign lim      = stage ? accel_limit : velocity_limit;
  assign past     = (time_sec > hold_seconds) ||
                    (time_sec == hold_seconds && time_nanosec != 30'd0);
  assign tgt_x    = past ? target_x : 32'd0;
  assign tgt_y    = past ? target_y : 32'd0;

  // Register read-back
  always_comb begin
    unique case (paddr[4:2])
      REG_VEL_GAIN:  prdata = {16'd0, velocity_gain};
      REG_ACC_GAIN:  prdata = {16'd0, accel_gain};
      REG_VEL_LIMIT: prdata = {1'b0, velocity_limit};
      REG_ACC_LIMIT: prdata = {1'b0, accel_limit};
      REG_HOLD:      prdata = hold_seconds;
      default:       prdata = 32'd0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, unit launches and operand selection
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && in_data.req_type == REQ_ODOM) state_next = S_PREP;
      S_PREP: state_next = S_MULX;
      S_MULX: if (mul_done) state_next = S_MULY;
      S_MULY: if (mul_done) state_next = S_SQX;
      S_SQX:  if (mul_done) state_next = S_SQY;
      S_SQY:  if (mul_done) state_next = S_SQL;
      S_SQL: begin
        if (mul_done) state_next = (n2 > prod[63:0]) ? S_SQRT : S_NEXT;
      end
      S_SQRT: if (sqrt_done) state_next = S_SCX;
      S_SCX:  if (mul_done) state_next = S_DIVX;
      S_DIVX: if (div_done) state_next = S_SCY;
      S_SCY:  if (mul_done) state_next = S_DIVY;
      S_DIVY: if (div_done) state_next = S_NEXT;
      S_NEXT: state_next = stage ? S_OUT : S_PREP;
      S_OUT:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase

    mul_start  = (state_next != state) &&
                 (state_next == S_MULX || state_next == S_MULY ||
                  state_next == S_SQX || state_next == S_SQY ||
                  state_next == S_SQL || state_next == S_SCX ||
                  state_next == S_SCY);
    div_start  = (state_next != state) &&
                 (state_next == S_DIVX || state_next == S_DIVY);
    sqrt_start = (state_next != state) && (state_next == S_SQRT);

    unique case (state_next)
      S_MULX: begin mul_a = mag33(ex); mul_b = {16'd0, gain}; end
      S_MULY: begin mul_a = mag33(ey); mul_b = {16'd0, gain}; end
      S_SQX:  begin mul_a = {1'b0, mag32(cx)}; mul_b = mag32(cx); end
      S_SQY:  begin mul_a = {1'b0, mag32(cy)}; mul_b = mag32(cy); end
      S_SQL:  begin mul_a = {2'b00, lim}; mul_b = {1'b0, lim}; end
      S_SCX:  begin mul_a = {1'b0, mag32(cx)}; mul_b = {1'b0, lim}; end
      S_SCY:  begin mul_a = {1'b0, mag32(cy)}; mul_b = {1'b0, lim}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Configuration registers and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_gain  <= 16'd2048;
      accel_gain     <= 16'd1229;
      velocity_limit <= 31'd131072;
      accel_limit    <= 31'd131072;
      hold_seconds   <= 32'd5;
      target_x       <= '0;
      target_y       <= '0;
      time_sec       <= '0;
      time_nanosec   <= '0;
      stage          <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[4:2])
          REG_VEL_GAIN:  velocity_gain  <= pwdata[15:0];
          REG_ACC_GAIN:  accel_gain     <= pwdata[15:0];
          REG_VEL_LIMIT: velocity_limit <= pwdata[30:0];
          REG_ACC_LIMIT: accel_limit    <= pwdata[30:0];
          REG_HOLD:      hold_seconds   <= pwdata;
          default: ;
        endcase
      end
      if (state == S_IDLE && in_valid) begin
        if (in_data.req_type == REQ_GOAL) begin
          target_x <= in_data.goal_x;
          target_y <= in_data.goal_y;
        end else if (in_data.req_type == REQ_CLOCK) begin
          time_sec     <= in_data.clock_sec;
          time_nanosec <= in_data.clock_nanosec;
        end
        stage <= 1'b0;
      end else if (state == S_NEXT) begin
        stage <= 1'b1;
      end
    end
  end

  // Working vector: errors, gain products, norm limiting
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      vx <= in_data.vel_x;
      vy <= in_data.vel_y;
      ex <= {tgt_x[31], tgt_x} - {in_data.pos_x[31], in_data.pos_x};
      ey <= {tgt_y[31], tgt_y} - {in_data.pos_y[31], in_data.pos_y};
    end
    if (state == S_NEXT) begin
      ex <= {cx[31], cx} - {vx[31], vx};
      ey <= {cy[31], cy} - {vy[31], vy};
    end
    if (state == S_MULX && mul_done) cx <= rnd_sat(prod, ex[32]);
    if (state == S_MULY && mul_done) cy <= rnd_sat(prod, ey[32]);
    if (state == S_SQX && mul_done) n2 <= prod[63:0];
    if (state == S_SQY && mul_done) n2 <= n2 + prod[63:0];
    if (state == S_DIVX && div_done) cx <= cx[31] ? (~quot + 32'd1) : quot;
    if (state == S_DIVY && div_done) cy <= cy[31] ? (~quot + 32'd1) : quot;
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data.accel_x <= cx;
      out_data.accel_y <= cy;
    end
  end

endmodule

/* verif/cpa_checker.sv */
`timescale 1ns / 100ps
// Checker for the cascaded proportional controller: predicts each acceleration
// command from the accepted transactions and compares it. Depends on cpa_pkg.
module cpa_checker
  import cpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  // Shadow configuration and controller state
  logic [15:0] kp_pos, kp_vel;
  logic [30:0] vel_limit, acc_limit;
  logic [31:0] hold_sec;
  logic signed [31:0] goal_x_q, goal_y_q;
  logic [31:0] now_sec;
  logic [29:0] now_nsec;
  rsp_t        accel_q[$];
  int          mismatches;

  assign pending = accel_q.size();

  // Gain product: drop 12 bits rounding half away from zero, saturate to 32 bits
  function automatic longint gain_scale(longint err, longint unsigned gain);
    longint prod;
    longint unsigned m, r;
    prod = err * longint'(gain);
    m = (prod < 0) ? longint'(-prod) : prod;
    r = (m + 64'd2048) >> 12;
    if (prod < 0)
      return (r > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(r);
    return (r > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(r);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale the vector down to the limit only when it is longer
  task automatic clamp_norm(inout longint x, inout longint y, input longint unsigned lim);
    longint unsigned ax, ay, n;
    ax = (x < 0) ? longint'(-x) : x;
    ay = (y < 0) ? longint'(-y) : y;
    if (ax * ax + ay * ay <= lim * lim) return;
    n = floor_sqrt(ax * ax + ay * ay);
    if (n == 0) return;
    ax = ax * lim / n;
    ay = ay * lim / n;
    x = (x < 0) ? -longint'(ax) : longint'(ax);
    y = (y < 0) ? -longint'(ay) : longint'(ay);
  endtask

  task automatic command_accel(input req_t r);
    longint tx, ty, dx, dy, ax, ay;
    rsp_t   c;
    tx = 0;
    ty = 0;
    if (now_sec > hold_sec || (now_sec == hold_sec && now_nsec != 0)) begin
      tx = goal_x_q;
      ty = goal_y_q;
    end
    dx = gain_scale(tx - longint'(r.pos_x), kp_pos);
    dy = gain_scale(ty - longint'(r.pos_y), kp_pos);
    clamp_norm(dx, dy, vel_limit);
    ax = gain_scale(dx - longint'(r.vel_x), kp_vel);
    ay = gain_scale(dy - longint'(r.vel_y), kp_vel);
    clamp_norm(ax, ay, acc_limit);
    c.accel_x = ax[31:0];
    c.accel_y = ay[31:0];
    accel_q.push_back(c);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      kp_pos    <= 16'd2048;
      kp_vel    <= 16'd1229;
      vel_limit <= 31'd131072;
      acc_limit <= 31'd131072;
      hold_sec  <= 32'd5;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
      now_sec   <= '0;
      now_nsec  <= '0;
      accel_q.delete();
      fail_count = 0;
      mismatches = 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_VEL_GAIN:  kp_pos    <= pwdata[15:0];
          REG_ACC_GAIN:  kp_vel    <= pwdata[15:0];
          REG_VEL_LIMIT: vel_limit <= pwdata[30:0];
          REG_ACC_LIMIT: acc_limit <= pwdata[30:0];
          REG_HOLD:      hold_sec  <= pwdata;
          default: ;
        endcase
      end
      // Request transactions
      if (in_valid && in_ready) begin
        case (in_data.req_type)
          REQ_ODOM:  command_accel(in_data);
          REQ_GOAL: begin
            goal_x_q <= in_data.goal_x;
            goal_y_q <= in_data.goal_y;
          end
          REQ_CLOCK: begin
            now_sec  <= in_data.clock_sec;
            now_nsec <= in_data.clock_nanosec;
          end
          default: ;
        endcase
      end
      // Result transactions
      if (out_valid && out_ready) begin
        if (accel_q.size() == 0) begin
          fail_count++;
          if (mismatches++ < 10)
            $display("unexpected result: accel %0d %0d", out_data.accel_x, out_data.accel_y);
        end else begin
          want = accel_q.pop_front();
          if (want.accel_x !== out_data.accel_x || want.accel_y !== out_data.accel_y) begin
            fail_count++;
            if (mismatches++ < 10)
              $display("accel mismatch: expected %0d %0d, got %0d %0d",
                       want.accel_x, want.accel_y, out_data.accel_x, out_data.accel_y);
          end
        end
      end
    end
  end

endmodule

/* verif/cascaded_p_accel_controller_2d_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the cascaded proportional controller: drives requests and
// register writes, gives the verdict. Uses cpa_pkg, cpa_checker and the DUT.
module cascaded_p_accel_controller_2d_tb
  import cpa_pkg::*;
();

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 1000;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  req_t        in_data;
  rsp_t        out_data;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, quiet;
  bit          calm, stall_req, stall_done;
  logic [31:0] hold_now;

  cascaded_p_accel_controller_2d u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cpa_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, one long hold-off when asked
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_done) begin
        stall_done = 1;
        for (int i = 0; i < 3000; i++) begin
          out_ready <= 0;
          @(posedge clk);
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  task automatic load_gains(input logic [15:0] vg, input logic [15:0] ag,
                            input logic [31:0] vl, input logic [31:0] al,
                            input logic [31:0] hs);
    apb_write(REG_VEL_GAIN, {16'd0, vg});
    apb_write(REG_ACC_GAIN, {16'd0, ag});
    apb_write(REG_VEL_LIMIT, vl);
    apb_write(REG_ACC_LIMIT, al);
    apb_write(REG_HOLD, hs);
    hold_now = hs;
  endtask

  // Wait until every command has arrived and the block has gone quiet
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(input req_t r);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                    : -$urandom_range(0, 1 << 20);
      2: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 24)
                                          : -$urandom_range(0, 1 << 24);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    r.pos_x = rand_q();
    r.pos_y = rand_q();
    r.vel_x = rand_q();
    r.vel_y = rand_q();
    r.goal_x = rand_q();
    r.goal_y = rand_q();
    r.clock_nanosec = $urandom_range(0, 3) == 0 ? 30'd0 : 30'($urandom);
    case ($urandom_range(0, 4))
      0: r.clock_sec = hold_now - 1;
      1: r.clock_sec = hold_now;
      2: r.clock_sec = hold_now + 1;
      3: r.clock_sec = 0;
      default: r.clock_sec = $urandom;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 60) r.req_type = REQ_ODOM;
    else if (pick < 80) r.req_type = REQ_GOAL;
    else if (pick < 95) r.req_type = REQ_CLOCK;
    else r.req_type = 2'd3;
    return r;
  endfunction

  function automatic req_t mk(input logic [1:0] kind, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c,
                              input logic [31:0] d);
    req_t r;
    r = '0;
    r.req_type = kind;
    r.pos_x = a; r.pos_y = b; r.vel_x = c; r.vel_y = d;
    r.goal_x = a; r.goal_y = b;
    r.clock_sec = a; r.clock_nanosec = b[29:0];
    return r;
  endfunction

  initial begin
    int   sent;
    req_t r;
    rst = 1; in_valid = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    calm = 0; stall_req = 0; stall_done = 0; hold_now = 32'd5;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: hold window, goal extremes, clock edge cases, unused request
    send(mk(REQ_ODOM, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0));
    send(mk(REQ_GOAL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    send(mk(REQ_ODOM, 32'h0, 32'h0, 32'h0, 32'h0));
    send(mk(REQ_CLOCK, 32'd5, 32'd0, 0, 0));
    send(mk(REQ_ODOM, 32'h0, 32'h0, 32'h0, 32'h0));
    send(mk(REQ_CLOCK, 32'd5, 32'd1, 0, 0));
    send(mk(REQ_ODOM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send(mk(REQ_CLOCK, 32'd5, 32'h3FFF_FFFF, 0, 0));
    send(mk(REQ_ODOM, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send(mk(REQ_CLOCK, 32'd4, 32'd999_999_999, 0, 0));
    send(mk(REQ_ODOM, 32'h0, 32'h0, 32'h0, 32'h0));
    send(mk(REQ_CLOCK, 32'hFFFF_FFFF, 32'd0, 0, 0));
    send(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(REQ_ODOM, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0800, 32'hFFFF_F800));
    send(mk(REQ_GOAL, 32'h0, 32'h0, 0, 0));
    send(mk(REQ_ODOM, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0));
    in_valid <= 0;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: load_gains(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        1: load_gains(16'd0, 16'd0, 32'd0, 32'd0, 32'd0);
        2: load_gains(16'd2048, 16'd1229, 32'd131072, 32'd131072, 32'd5);
        3: load_gains(16'd4096, 16'd4096, 32'd65536, 32'd65536, 32'd1);
        default: load_gains(16'($urandom), 16'($urandom),
                            $urandom_range(0, 32'h7FFF_FFFF),
                            $urandom_range(0, 1 << 24), $urandom_range(0, 8));
      endcase
      calm = (ph == 3);
      stall_req = (ph == 4);
      sent = 0;
      while (sent < 242) begin
        r = rand_req();
        send(r);
        sent++;
      end
      in_valid <= 0;
    end
    calm = 0;

    drain();
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
